// File: sv/kscl_pkg.sv
package kscl_pkg;

    typedef enum logic [2:0] {
        OP_TICK          = 3'd0,
        OP_ENTER_ATTEMPT = 3'd1,
        OP_ENTER_MAIN    = 3'd2,
        OP_ENTER_RESET   = 3'd3,
        OP_CMP_MAIN      = 3'd4,
        OP_CMP_RESET     = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        TGT_NONE    = 2'd0,
        TGT_ATTEMPT = 2'd1,
        TGT_MAIN    = 2'd2,
        TGT_RESET   = 2'd3
    } target_t;

    localparam int CHAR_W = 7;
    localparam int TICK_W = 16;
    localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 16'd32;

    localparam logic [CHAR_W-1:0] CHAR_X    = 7'd88;  // 'X'
    localparam logic [CHAR_W-1:0] CHAR_FIVE = 7'd53;  // '5'
    localparam logic [CHAR_W-1:0] CHAR_STAR = 7'd42;  // '*'

    // Key released during a scan tick, handed from the scanner to the code stores.
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] char_code;
    } key_evt_t;

    typedef struct packed {
        logic              entry_active;
        logic              entry_done;
        logic              compare_valid;
        logic              code_match;
    } code_status_t;

    typedef struct packed {
        logic [3:0]        row_drive;
        key_evt_t          key;
        code_status_t      status;
    } result_t;

    // Rows "123A", "456B", "789C", "*0#D".
    function automatic logic [CHAR_W-1:0] key_map(input logic [1:0] row, input logic [1:0] col);
        logic [CHAR_W-1:0] ch;
        unique case ({row, col})
            4'h0: ch = 7'd49;  // '1'
            4'h1: ch = 7'd50;  // '2'
            4'h2: ch = 7'd51;  // '3'
            4'h3: ch = 7'd65;  // 'A'
            4'h4: ch = 7'd52;  // '4'
            4'h5: ch = 7'd53;  // '5'
            4'h6: ch = 7'd54;  // '6'
            4'h7: ch = 7'd66;  // 'B'
            4'h8: ch = 7'd55;  // '7'
            4'h9: ch = 7'd56;  // '8'
            4'hA: ch = 7'd57;  // '9'
            4'hB: ch = 7'd67;  // 'C'
            4'hC: ch = 7'd42;  // '*'
            4'hD: ch = 7'd48;  // '0'
            4'hE: ch = 7'd35;  // '#'
            4'hF: ch = 7'd68;  // 'D'
            default: ch = 7'd0;
        endcase
        return ch;
    endfunction

endpackage

// File: sv/kscl_scan.sv
module kscl_scan
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [kscl_pkg::TICK_W-1:0]  cfg_data,
    input  logic                         go,
    input  logic [2:0]                   opcode,
    input  logic [3:0]                   column_lines,
    output logic [3:0]                   row_drive,
    output kscl_pkg::key_evt_t           key
);

    logic [kscl_pkg::TICK_W-1:0] ticks_reg;
    logic [1:0]                  row_reg, row_next;
    logic                        wait_reg, wait_next;
    logic [1:0]                  col_reg, col_next;
    logic [kscl_pkg::TICK_W-1:0] count_reg, count_next;
    logic                        col_found;
    logic [1:0]                  col_first;

    assign row_drive = ~(4'b0001 << row_reg);

    always_comb
    begin
        col_found = 1'b1;
        col_first = 2'd0;
        priority if (!column_lines[0]) col_first = 2'd0;
        else if (!column_lines[1])     col_first = 2'd1;
        else if (!column_lines[2])     col_first = 2'd2;
        else if (!column_lines[3])     col_first = 2'd3;
        else                           col_found = 1'b0;
    end

    always_comb
    begin
        row_next        = row_reg;
        wait_next       = wait_reg;
        col_next        = col_reg;
        count_next      = count_reg;
        key.valid       = 1'b0;
        key.char_code   = '0;
        if (go && kscl_pkg::opcode_t'(opcode) == kscl_pkg::OP_TICK)
        begin
            if (!wait_reg)
            begin
                if (col_found)
                begin
                    col_next   = col_first;
                    wait_next  = 1'b1;
                    count_next = ticks_reg;
                end
                else
                begin
                    row_next = row_reg + 2'd1;
                end
            end
            else if (count_reg != '0)
            begin
                count_next = count_reg - kscl_pkg::TICK_W'(1);
            end
            else
            begin
                wait_next = 1'b0;
                // Column back high after the wait means the key was released.
                if (column_lines[col_reg])
                begin
                    key.valid     = 1'b1;
                    key.char_code = kscl_pkg::key_map(row_reg, col_reg);
                    row_next      = 2'd0;
                end
                else
                begin
                    row_next = row_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= kscl_pkg::DEBOUNCE_RESET;
            row_reg   <= 2'd0;
            wait_reg  <= 1'b0;
            col_reg   <= 2'd0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                ticks_reg <= cfg_data;
            end
            row_reg   <= row_next;
            wait_reg  <= wait_next;
            col_reg   <= col_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: sv/kscl_codes.sv
module kscl_codes
#(
    parameter int CODE_LENGTH = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     go,
    input  logic [2:0]               opcode,
    input  kscl_pkg::key_evt_t       key,
    output kscl_pkg::code_status_t   status
);

    localparam int PLACE_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam logic [PLACE_W-1:0] LAST_PLACE = PLACE_W'(CODE_LENGTH - 1);

    logic [kscl_pkg::CHAR_W-1:0] attempt_reg [CODE_LENGTH];
    logic [kscl_pkg::CHAR_W-1:0] main_reg    [CODE_LENGTH];
    logic [kscl_pkg::CHAR_W-1:0] reset_reg   [CODE_LENGTH];

    kscl_pkg::target_t           target_reg, target_next;
    logic [PLACE_W-1:0]          place_reg, place_next;

    logic                        wr_attempt, wr_main, wr_reset;
    logic [PLACE_W-1:0]          wr_idx;
    logic [kscl_pkg::CHAR_W-1:0] wr_data;
    logic                        eq_main, eq_reset;
    kscl_pkg::target_t           wr_target;

    always_comb
    begin
        eq_main  = 1'b1;
        eq_reset = 1'b1;
        for (int k = 0; k < CODE_LENGTH; k++)
        begin
            if (attempt_reg[k] != main_reg[k])  eq_main  = 1'b0;
            if (attempt_reg[k] != reset_reg[k]) eq_reset = 1'b0;
        end
    end

    always_comb
    begin
        target_next          = target_reg;
        place_next           = place_reg;
        wr_target            = kscl_pkg::TGT_NONE;
        wr_idx               = place_reg;
        wr_data              = key.char_code;
        status.entry_done    = 1'b0;
        status.compare_valid = 1'b0;
        status.code_match    = 1'b0;
        if (go)
        begin
            unique case (kscl_pkg::opcode_t'(opcode))
                kscl_pkg::OP_TICK:
                begin
                    if (key.valid && target_reg != kscl_pkg::TGT_NONE)
                    begin
                        wr_target = target_reg;
                        if (place_reg == LAST_PLACE)
                        begin
                            status.entry_done = 1'b1;
                            target_next       = kscl_pkg::TGT_NONE;
                            place_next        = '0;
                        end
                        else
                        begin
                            place_next = place_reg + PLACE_W'(1);
                        end
                    end
                end
                kscl_pkg::OP_ENTER_ATTEMPT, kscl_pkg::OP_ENTER_MAIN,
                kscl_pkg::OP_ENTER_RESET:
                begin
                    // A new entry drops any entry in progress and marks the last place.
                    target_next = kscl_pkg::target_t'(opcode[1:0]);
                    place_next  = '0;
                    wr_target   = kscl_pkg::target_t'(opcode[1:0]);
                    wr_idx      = LAST_PLACE;
                    wr_data     = kscl_pkg::CHAR_X;
                end
                kscl_pkg::OP_CMP_MAIN:
                begin
                    status.compare_valid = 1'b1;
                    status.code_match    = eq_main;
                end
                kscl_pkg::OP_CMP_RESET:
                begin
                    status.compare_valid = 1'b1;
                    status.code_match    = eq_reset;
                end
                default:
                begin
                end
            endcase
        end
        status.entry_active = (target_next != kscl_pkg::TGT_NONE);
    end

    assign wr_attempt = (wr_target == kscl_pkg::TGT_ATTEMPT);
    assign wr_main    = (wr_target == kscl_pkg::TGT_MAIN);
    assign wr_reset   = (wr_target == kscl_pkg::TGT_RESET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= kscl_pkg::TGT_NONE;
            place_reg  <= '0;
            for (int k = 0; k < CODE_LENGTH; k++)
            begin
                attempt_reg[k] <= kscl_pkg::CHAR_X;
                main_reg[k]    <= kscl_pkg::CHAR_FIVE;
                reset_reg[k]   <= kscl_pkg::CHAR_STAR;
            end
        end
        else
        begin
            target_reg <= target_next;
            place_reg  <= place_next;
            for (int k = 0; k < CODE_LENGTH; k++)
            begin
                if (wr_idx == PLACE_W'(k))
                begin
                    if (wr_attempt) attempt_reg[k] <= wr_data;
                    if (wr_main)    main_reg[k]    <= wr_data;
                    if (wr_reset)   reset_reg[k]   <= wr_data;
                end
            end
        end
    end

endmodule

// File: sv/keypad_scan_code_lock_core.sv
// Keypad scanner and code lock.
// Input channel (in_valid/in_ready): one beat carries an opcode and the sampled
// column lines. Opcode 0 is a scan tick; 1 to 3 start an entry into the attempt,
// main or reset code store; 4 and 5 compare the attempt with the main or reset
// code. Every input beat yields exactly one output beat (out_valid/out_ready)
// with the row driven during that tick, any released key, and entry and
// compare flags.
// Configuration channel (cfg_valid/cfg_ready): one beat writes the 16-bit
// debounce tick count; cfg_ready is always high. Write it only while no item
// is in flight.
// A beat passes an input register and a result register: its result is on the
// output once it is in the result register. While out_ready stays high, one
// beat per cycle is sustained, because all work for a beat is done
// combinationally between those two registers.
// When the receiver stalls, the held result stays in the result register and
// one more beat waits in the input register; in_ready then drops.
// Reset clears the scanner to the first row, ends any entry, sets the debounce
// count to 32 and loads the stores: attempt all 'X', main all '5', reset all '*'.
module keypad_scan_code_lock_core
#(
    parameter int CODE_LENGTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [3:0]  column_lines,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  row_drive,
    output logic        key_valid,
    output logic [6:0]  key_char,
    output logic        entry_active,
    output logic        entry_done,
    output logic        compare_valid,
    output logic        code_match
);

    logic                   in_valid_reg;
    logic [2:0]             opcode_reg;
    logic [3:0]             cols_reg;
    logic                   out_valid_reg;
    kscl_pkg::result_t      result_reg, result_next;
    logic                   go;
    logic [3:0]             scan_row_drive;
    kscl_pkg::key_evt_t     key;
    kscl_pkg::code_status_t status;

    assign cfg_ready = 1'b1;
    assign go        = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || go;

    kscl_scan u_scan
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid),
        .cfg_data     (cfg_data),
        .go           (go),
        .opcode       (opcode_reg),
        .column_lines (cols_reg),
        .row_drive    (scan_row_drive),
        .key          (key)
    );

    kscl_codes #(.CODE_LENGTH(CODE_LENGTH)) u_codes
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go),
        .opcode (opcode_reg),
        .key    (key),
        .status (status)
    );

    always_comb
    begin
        result_next.row_drive = scan_row_drive;
        result_next.key       = key;
        result_next.status    = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            opcode_reg <= opcode;
            cols_reg   <= column_lines;
        end
        if (go)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign row_drive     = result_reg.row_drive;
    assign key_valid     = result_reg.key.valid;
    assign key_char      = result_reg.key.char_code;
    assign entry_active  = result_reg.status.entry_active;
    assign entry_done    = result_reg.status.entry_done;
    assign compare_valid = result_reg.status.compare_valid;
    assign code_match    = result_reg.status.code_match;

endmodule
